### rtl/core/per_kind_sliding_window_limiter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding window limiter
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PER_KIND_SLIDING_WINDOW_LIMITER_DEFINES_SVH
`define PER_KIND_SLIDING_WINDOW_LIMITER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PKSWL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkswl assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PKSWL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkswl assertion failed");

`endif

### rtl/core/pkswl_pkg.sv
// ----------------------------------------------------------------------------
// pkswl_pkg
// Types and constants shared by the sliding window limiter modules.
// ----------------------------------------------------------------------------
package pkswl_pkg;

    localparam int LOG_DEPTH = 64;
    localparam int KIND_BITS = 8;
    localparam int TIME_BITS = 32;
    localparam int SLOT_W    = $clog2(LOG_DEPTH);

    localparam int LIMIT_W   = 12;
    localparam int WINDOW_W  = 17;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 2;
    localparam int COUNT_W   = 7;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET  = LIMIT_W'(3);
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(3600);

    localparam logic [1:0] FUNC_ATTEMPT = 2'd0;
    localparam logic [1:0] FUNC_QUERY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    // Command broadcast to every cell for the whole scan of one item.
    typedef struct packed {
        logic [1:0]           func;
        logic [KIND_BITS-1:0] kind;
        logic [TIME_BITS-1:0] now;
        logic [TIME_BITS-1:0] cutoff;
        logic                 no_expire;
    } cmd_t;

    // Token that walks the chain, one cell per cycle.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] kc;
        logic [COUNT_W-1:0] tc;
        logic               over;
    } token_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                   input logic inc);
        logic [COUNT_W-1:0] r;
        r = c;
        if (inc && (c != COUNT_MAX))
        begin
            r = c + COUNT_W'(1);
        end
        return r;
    endfunction

endpackage

### rtl/core/per_kind_sliding_window_limiter.sv
// ----------------------------------------------------------------------------
// per_kind_sliding_window_limiter
// Per-kind sliding window attempt limiter built as a chain of log cells.
// ----------------------------------------------------------------------------
// A launch register starts the token, which walks the 64-cell chain through
// one register per log slot; the result is captured, then loaded for output.
// No new item is taken until the last result is in the output register.
// A finished result waits in the output register while the next item is taken.
// Reset (rst_n, asynchronous, active low) clears every entry valid bit, the
// write slot and the handshake state, and loads the register reset values.
// ----------------------------------------------------------------------------
module per_kind_sliding_window_limiter
    import pkswl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Configuration write port.
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Input channel.
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [KIND_BITS-1:0] kind_id,
    input  logic [TIME_BITS-1:0] now_seconds,
    // Result channel.
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 allowed,
    output logic [COUNT_W-1:0]   kind_cnt,
    output logic [COUNT_W-1:0]   total_count,
    output logic                 overwrote_live
);

    // Configuration registers.
    logic [LIMIT_W-1:0]  limit_reg;
    logic [WINDOW_W-1:0] window_reg;

    // Control state.
    state_t              state_reg, state_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                launch_reg;
    cmd_t                cmd_reg;

    // Result waiting to be moved into the output register.
    logic                pend_allowed_reg;
    logic [COUNT_W-1:0]  pend_kc_reg;
    logic [COUNT_W-1:0]  pend_tc_reg;
    logic                pend_over_reg;

    // Output register.
    logic                out_valid_reg;
    logic                allowed_reg;
    logic [COUNT_W-1:0]  kind_cnt_reg;
    logic [COUNT_W-1:0]  total_count_reg;
    logic                over_reg;

    // Strobes from the state decoder and the end of the chain.
    logic                accept;
    logic                scan_done;
    logic                load_out;

    logic [TIME_BITS-1:0] window_ext;
    token_t               tok [LOG_DEPTH+1];

    assign window_ext = TIME_BITS'(window_reg);
    assign scan_done  = tok[LOG_DEPTH].valid;

    // The token enters the first cell in the cycle after acceptance with
    // zero counts; for an attempt or query each cell adds its own live entry.
    always_comb
    begin
        tok[0].valid = launch_reg;
        tok[0].kc    = '0;
        tok[0].tc    = '0;
        tok[0].over  = 1'b0;
    end

    for (genvar i = 0; i < LOG_DEPTH; i++)
    begin : g_cell
        pkswl_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cmd       (cmd_reg),
            .write_sel (slot_reg == SLOT_W'(i)),
            .tok_in    (tok[i]),
            .tok_out   (tok[i+1])
        );
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        in_ready = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_HOLD:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    assign accept = in_valid && in_ready;

    // The write slot advances after an attempt has been recorded and returns
    // to zero on a clear. It stays fixed for the whole scan.
    always_comb
    begin
        slot_next = slot_reg;
        if ((state_reg == ST_SCAN) && scan_done)
        begin
            case (cmd_reg.func)
                FUNC_ATTEMPT:
                begin
                    if (slot_reg == SLOT_W'(LOG_DEPTH - 1))
                    begin
                        slot_next = '0;
                    end
                    else
                    begin
                        slot_next = slot_reg + SLOT_W'(1);
                    end
                end
                FUNC_CLEAR:
                begin
                    slot_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            slot_reg      <= '0;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            limit_reg     <= LIMIT_RESET;
            window_reg    <= WINDOW_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            slot_reg   <= slot_next;
            launch_reg <= accept;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT:  limit_reg  <= cfg_wdata[LIMIT_W-1:0];
                    CFG_WINDOW: window_reg <= cfg_wdata[WINDOW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Payload registers. The cutoff and the no-expire flag are worked out once
    // at acceptance so every cell only needs a compare.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg.func      <= func;
            cmd_reg.kind      <= kind_id;
            cmd_reg.now       <= now_seconds;
            cmd_reg.cutoff    <= now_seconds - window_ext;
            cmd_reg.no_expire <= now_seconds < window_ext;
        end
        if ((state_reg == ST_SCAN) && scan_done)
        begin
            case (cmd_reg.func)
                FUNC_ATTEMPT:
                begin
                    pend_allowed_reg <= {{(LIMIT_W-COUNT_W){1'b0}}, tok[LOG_DEPTH].kc}
                                        < limit_reg;
                    pend_kc_reg      <= tok[LOG_DEPTH].kc;
                    pend_tc_reg      <= tok[LOG_DEPTH].tc;
                    pend_over_reg    <= tok[LOG_DEPTH].over;
                end
                FUNC_QUERY:
                begin
                    pend_allowed_reg <= 1'b0;
                    pend_kc_reg      <= tok[LOG_DEPTH].kc;
                    pend_tc_reg      <= tok[LOG_DEPTH].tc;
                    pend_over_reg    <= 1'b0;
                end
                default:
                begin
                    // Clear and the unused code report all zeros.
                    pend_allowed_reg <= 1'b0;
                    pend_kc_reg      <= '0;
                    pend_tc_reg      <= '0;
                    pend_over_reg    <= 1'b0;
                end
            endcase
        end
        if (load_out)
        begin
            allowed_reg     <= pend_allowed_reg;
            kind_cnt_reg    <= pend_kc_reg;
            total_count_reg <= pend_tc_reg;
            over_reg        <= pend_over_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign allowed        = allowed_reg;
    assign kind_cnt       = kind_cnt_reg;
    assign total_count    = total_count_reg;
    assign overwrote_live = over_reg;

endmodule

### rtl/core/pkswl_cell.sv
// ----------------------------------------------------------------------------
// pkswl_cell
// One log slot: holds an entry and updates the passing count token.
// ----------------------------------------------------------------------------
module pkswl_cell
    import pkswl_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  cmd_t   cmd,
    input  logic   write_sel,
    input  token_t tok_in,
    output token_t tok_out
);

    logic [TIME_BITS-1:0] time_reg, time_next;
    logic [KIND_BITS-1:0] kind_reg, kind_next;
    logic                 valid_reg, valid_next;
    token_t               tok_reg, tok_next;
    logic                 live;
    logic                 counting;

    assign live = valid_reg && (cmd.no_expire || (time_reg >= cmd.cutoff));
    assign counting = (cmd.func == FUNC_ATTEMPT) || (cmd.func == FUNC_QUERY);

    always_comb
    begin
        time_next  = time_reg;
        kind_next  = kind_reg;
        valid_next = valid_reg;
        tok_next   = tok_in;
        if (tok_in.valid)
        begin
            if (counting)
            begin
                tok_next.tc = sat_inc(tok_in.tc, live);
                tok_next.kc = sat_inc(tok_in.kc, live && (kind_reg == cmd.kind));
            end
            case (cmd.func)
                FUNC_ATTEMPT:
                begin
                    // Expired entries are dropped as the token passes.
                    valid_next = live;
                    if (write_sel)
                    begin
                        tok_next.over = live;
                        time_next     = cmd.now;
                        kind_next     = cmd.kind;
                        valid_next    = 1'b1;
                    end
                end
                FUNC_CLEAR:
                begin
                    valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        kind_reg <= kind_next;
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/pkswl_checker.sv
// ----------------------------------------------------------------------------
// pkswl_checker
// Port-level checks on the sliding window limiter, bound to the top level.
// ----------------------------------------------------------------------------
`include "per_kind_sliding_window_limiter_defines.svh"

module pkswl_checker
    import pkswl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               allowed,
    input logic [COUNT_W-1:0] kind_cnt,
    input logic [COUNT_W-1:0] total_count,
    input logic               overwrote_live
);

    // A stalled result stays offered.
    `PKSWL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

    // One item at a time: the block is busy right after taking a transaction.
    `PKSWL_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

    // Entries of one kind are a subset of all live entries.
    `PKSWL_ASSERT_SAME(a_kind_le_total, out_valid, kind_cnt <= total_count)

    // The log never holds more live entries than it has slots.
    `PKSWL_ASSERT_SAME(a_total_le_depth, out_valid, total_count <= COUNT_W'(LOG_DEPTH))

    // Overwriting a live slot means at least one entry was live.
    `PKSWL_ASSERT_SAME(a_over_implies_live, out_valid && overwrote_live, total_count != '0)

endmodule

bind per_kind_sliding_window_limiter pkswl_checker u_pkswl_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .allowed        (allowed),
    .kind_cnt       (kind_cnt),
    .total_count    (total_count),
    .overwrote_live (overwrote_live)
);

### test/pkswl_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pkswl_monitor
// Watches the ports of the sliding window limiter. Tracks register writes and
// accepted requests, predicts the result of each one from its own copy of the
// attempt log, and compares every accepted result against the oldest
// prediction.
// ----------------------------------------------------------------------------
module pkswl_monitor
    import pkswl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [1:0]           func,
    input  logic [KIND_BITS-1:0] kind_id,
    input  logic [TIME_BITS-1:0] now_seconds,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic                 allowed,
    input  logic [COUNT_W-1:0]   kind_cnt,
    input  logic [COUNT_W-1:0]   total_count,
    input  logic                 overwrote_live,
    output int                   errors,
    output int                   pending
);

    typedef struct packed {
        logic               allowed;
        logic [COUNT_W-1:0] kind_cnt;
        logic [COUNT_W-1:0] total_count;
        logic               overwrote_live;
    } verdict_t;

    logic [LIMIT_W-1:0]   limit_reg;
    logic [WINDOW_W-1:0]  window_reg;
    logic [TIME_BITS-1:0] log_time [LOG_DEPTH];
    logic [KIND_BITS-1:0] log_kind [LOG_DEPTH];
    logic                 log_used [LOG_DEPTH];
    logic [SLOT_W-1:0]    next_slot;
    verdict_t             verdict_q [$];
    int                   result_no;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $realtime, result_no, msg);
        errors++;
    endtask

    // An entry stamped at or after the cutoff is live; a cutoff below zero
    // keeps every valid entry live.
    function automatic logic slot_is_live(input int s, input logic [TIME_BITS-1:0] now);
        logic [TIME_BITS-1:0] win;
        win = TIME_BITS'(window_reg);
        if (!log_used[s])
            return 1'b0;
        if (now < win)
            return 1'b1;
        return log_time[s] >= now - win;
    endfunction

    function automatic void count_live(input logic [KIND_BITS-1:0] kind,
                                       input logic [TIME_BITS-1:0] now,
                                       output logic [COUNT_W-1:0]  kc,
                                       output logic [COUNT_W-1:0]  tc);
        kc = '0;
        tc = '0;
        for (int s = 0; s < LOG_DEPTH; s++)
        begin
            if (slot_is_live(s, now))
            begin
                if (tc != COUNT_MAX)
                    tc = tc + 1'b1;
                if (log_kind[s] == kind && kc != COUNT_MAX)
                    kc = kc + 1'b1;
            end
        end
    endfunction

    // Applies one request to the log copy and returns the result it yields.
    function automatic verdict_t judge_request(input logic [1:0]           f,
                                               input logic [KIND_BITS-1:0] k,
                                               input logic [TIME_BITS-1:0] now);
        verdict_t           v;
        logic [COUNT_W-1:0] kc;
        logic [COUNT_W-1:0] tc;
        v = '0;
        case (f)
            FUNC_ATTEMPT:
            begin
                for (int s = 0; s < LOG_DEPTH; s++)
                    if (log_used[s] && !slot_is_live(s, now))
                        log_used[s] = 1'b0;
                count_live(k, now, kc, tc);
                v.kind_cnt       = kc;
                v.total_count    = tc;
                v.allowed        = LIMIT_W'(kc) < limit_reg;
                v.overwrote_live = log_used[next_slot];
                log_time[next_slot] = now;
                log_kind[next_slot] = k;
                log_used[next_slot] = 1'b1;
                next_slot = next_slot + 1'b1;
            end
            FUNC_QUERY:
            begin
                count_live(k, now, kc, tc);
                v.kind_cnt    = kc;
                v.total_count = tc;
            end
            FUNC_CLEAR:
            begin
                for (int s = 0; s < LOG_DEPTH; s++)
                    log_used[s] = 1'b0;
                next_slot = '0;
            end
            default:
            begin
            end
        endcase
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        verdict_t want;
        if (!rst_n)
        begin
            limit_reg  = LIMIT_RESET;
            window_reg = WINDOW_RESET;
            for (int s = 0; s < LOG_DEPTH; s++)
                log_used[s] = 1'b0;
            next_slot = '0;
            verdict_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_LIMIT:  limit_reg  = cfg_wdata[LIMIT_W-1:0];
                    CFG_WINDOW: window_reg = cfg_wdata[WINDOW_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want = verdict_q.pop_front();
                    if (allowed !== want.allowed)
                        report_mismatch($sformatf("allowed %b, expected %b",
                                                  allowed, want.allowed));
                    if (kind_cnt !== want.kind_cnt)
                        report_mismatch($sformatf("kind_cnt %0d, expected %0d",
                                                  kind_cnt, want.kind_cnt));
                    if (total_count !== want.total_count)
                        report_mismatch($sformatf("total_count %0d, expected %0d",
                                                  total_count, want.total_count));
                    if (overwrote_live !== want.overwrote_live)
                        report_mismatch($sformatf("overwrote_live %b, expected %b",
                                                  overwrote_live, want.overwrote_live));
                end
                result_no++;
            end
            if (in_valid && in_ready)
                verdict_q.insert(verdict_q.size(),
                                 judge_request(func, kind_id, now_seconds));
            pending <= verdict_q.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the per-kind sliding window limiter. A short directed run
// covers the register reset values, expiry, blocking, queries, clears, the
// unused function code, zero window and zero limit, entries stamped in the
// future and the extremes of time and kind. Random phases under several
// register settings follow, with bursty input traffic and a stalling result
// side. A monitor beside the block predicts and checks every result.
// ----------------------------------------------------------------------------
module tb;
    import pkswl_pkg::*;

    // The fourth function code is not defined; the block must answer with
    // zeros and leave the log alone.
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    // Register indexes past the last register; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(3);

    // Point at which the result side stops taking results for a long time.
    localparam int HOLD_AFTER  = 120;
    localparam int HOLD_CYCLES = 600;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           func;
    logic [KIND_BITS-1:0] kind_id;
    logic [TIME_BITS-1:0] now_seconds;
    logic                 out_valid;
    logic                 out_ready;
    logic                 allowed;
    logic [COUNT_W-1:0]   kind_cnt;
    logic [COUNT_W-1:0]   total_count;
    logic                 overwrote_live;

    int                   errors;
    int                   pending;
    int                   results_seen;

    // Sender state: items left in the current burst and the running clock
    // value that the random phases hand to the block.
    int                   burst_left;
    logic [TIME_BITS-1:0] now_t;

    per_kind_sliding_window_limiter i_dut (.*);

    pkswl_monitor i_monitor (.*);

    always #5 clk = ~clk;

    // Count result transactions; the result side uses this to decide when
    // to start its long hold-off.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            results_seen <= results_seen + 1;
    end

    // Offer one request and wait until the block takes it. Valid is left
    // high on return so a following item in the same burst goes out without
    // a bubble. Between bursts the sender lowers valid for a random gap,
    // sometimes long enough to land anywhere in the block's scan.
    task automatic send_item(input logic [1:0]           f,
                             input logic [KIND_BITS-1:0] k,
                             input logic [TIME_BITS-1:0] t);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
                gap = $urandom_range(0, 80);
            else
                gap = $urandom_range(0, 4);
            burst_left = $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid    <= 1'b1;
        func        <= f;
        kind_id     <= k;
        now_seconds <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Drive one register write; the caller lowers the write enable after the
    // last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    // Load both registers. The limit goes out with random junk above its
    // twelve bits, and one write to an unused index is thrown in first.
    task automatic configure(input logic [LIMIT_W-1:0] limit, input logic [WINDOW_W-1:0] window);
        write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_W'($urandom));
        write_reg(CFG_LIMIT, {5'($urandom), limit});
        write_reg(CFG_WINDOW, window);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering and wait until every expected result has come back.
    // The first edge lets the monitor's count catch up with the last
    // accepted transaction.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random traffic. Most requests are attempts on a few neighboring kinds
    // with a slowly advancing clock, so counts build up against the limit
    // and entries age out. A few requests use any kind, jump the clock
    // forward, or step it back so that some entries sit in the future.
    task automatic run_random_phase(input int count, input int step_max,
                                    input int kind_span, input int clear_pct);
        logic [1:0]           f;
        logic [KIND_BITS-1:0] k;
        logic [KIND_BITS-1:0] kind_base;
        logic [TIME_BITS:0]   sum;
        int unsigned          delta;
        int                   pick;
        kind_base = KIND_BITS'($urandom);
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 74)
                f = FUNC_ATTEMPT;
            else if (pick < 92)
                f = FUNC_QUERY;
            else if (pick < 92 + clear_pct)
                f = FUNC_CLEAR;
            else if (pick < 96)
                f = FUNC_SPARE;
            else
                f = FUNC_ATTEMPT;

            if ($urandom_range(0, 9) == 0)
                k = KIND_BITS'($urandom);
            else
                k = kind_base + KIND_BITS'($urandom_range(0, kind_span - 1));

            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                delta = $urandom_range(0, 2 * step_max + 1);
                if (delta > now_t)
                    now_t = '0;
                else
                    now_t = now_t - delta;
            end
            else
            begin
                if (pick < 7)
                    delta = $urandom_range(0, 200000);
                else
                    delta = $urandom_range(0, step_max);
                sum   = {1'b0, now_t} + (TIME_BITS + 1)'(delta);
                now_t = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];
            end
            send_item(f, k, now_t);
        end
    endtask

    // Result side. It normally follows a pattern of its own: stretches of
    // steady acceptance, coin-flip acceptance and sparse acceptance. Once,
    // after enough results have passed, it refuses results for a long run of
    // cycles while the sender keeps offering, so the output register fills
    // and the block has to hold off its input.
    initial
    begin : result_side
        int  mode;
        int  seg_left;
        int  hold_left;
        bit  held;
        mode      = 0;
        seg_left  = 0;
        hold_left = 0;
        held      = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!held && results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = $urandom_range(0, 2);
                    seg_left = $urandom_range(20, 200);
                end
                seg_left--;
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Last-resort guard in case the block locks up.
    initial
    begin : watchdog
        #5_000_000;
        $display("** per_kind_sliding_window_limiter: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        in_valid     = 1'b0;
        func         = FUNC_ATTEMPT;
        kind_id      = '0;
        now_seconds  = '0;
        results_seen = 0;
        burst_left   = 0;
        now_t        = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: three attempts per kind in a 3600 second window.
        // The early attempts fall below the window length, so nothing can
        // expire yet; the fourth attempt of kind 0 is blocked.
        send_item(FUNC_QUERY,   8'h00, 32'd0);
        send_item(FUNC_ATTEMPT, 8'h00, 32'd0);
        send_item(FUNC_ATTEMPT, 8'h00, 32'd10);
        send_item(FUNC_ATTEMPT, 8'h00, 32'd20);
        send_item(FUNC_ATTEMPT, 8'h00, 32'd30);
        send_item(FUNC_ATTEMPT, 8'hFF, 32'd40);
        // At 3620 the cutoff is 20: the entries at 0 and 10 have aged out
        // while the one at exactly the cutoff stays.
        send_item(FUNC_QUERY,   8'h00, 32'd3620);
        send_item(FUNC_ATTEMPT, 8'h00, 32'd3620);
        send_item(FUNC_SPARE,   8'h5A, 32'd3620);
        send_item(FUNC_CLEAR,   8'hFF, 32'd3621);
        send_item(FUNC_QUERY,   8'hFF, 32'd3621);
        wait_idle();

        // Zero limit blocks everything; a zero window keeps only entries
        // stamped at or after now, including one stamped in the future.
        configure(12'd0, 17'd0);
        send_item(FUNC_ATTEMPT, 8'h01, 32'd5000);
        send_item(FUNC_ATTEMPT, 8'h01, 32'd5000);
        send_item(FUNC_QUERY,   8'h01, 32'd5001);
        send_item(FUNC_ATTEMPT, 8'h02, 32'd6000);
        send_item(FUNC_QUERY,   8'h02, 32'd5999);
        wait_idle();

        // Largest limit and window with the clock at its top value.
        configure(12'hFFF, 17'h1FFFF);
        send_item(FUNC_ATTEMPT, 8'hA5, 32'hFFFF_FFFF);
        send_item(FUNC_ATTEMPT, 8'h00, 32'hFFFF_FFFF);
        send_item(FUNC_QUERY,   8'hA5, 32'hFFFF_FFFF);
        send_item(FUNC_CLEAR,   8'h00, 32'hFFFF_FFFF);
        wait_idle();

        // Short window with a small limit: constant turnover of the log.
        now_t = '0;
        configure(12'd3, 17'd50);
        run_random_phase(70, 4, 3, 3);
        wait_idle();

        // Window of one second and a limit of one.
        configure(12'd1, 17'd1);
        run_random_phase(60, 2, 2, 3);
        wait_idle();

        // A full day window with no clears: the log wraps and overwrites
        // entries that are still live, and the counts reach the log depth.
        configure(12'hFFF, 17'd86400);
        run_random_phase(80, 1, 4, 0);
        wait_idle();

        // Clock close to its top value with small random settings.
        now_t = 32'hFFFF_F000 + TIME_BITS'($urandom_range(0, 255));
        configure(LIMIT_W'($urandom_range(0, 8)), WINDOW_W'($urandom_range(1, 300)));
        run_random_phase(70, 8, 3, 3);
        wait_idle();

        // Settings drawn from the full register ranges, random clock base.
        now_t = TIME_BITS'($urandom);
        configure(LIMIT_W'($urandom), WINDOW_W'($urandom));
        run_random_phase(60, 5000, 8, 3);
        wait_idle();

        // Widest window, limit of two, rare clears.
        configure(12'd2, 17'h1FFFF);
        run_random_phase(70, 3, 2, 1);
        wait_idle();

        // Allow for any stray result past the block's latency.
        repeat (100) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** per_kind_sliding_window_limiter: PASSED **");
        else
            $display("** per_kind_sliding_window_limiter: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/pkswl_pkg.sv
rtl/core/pkswl_cell.sv
rtl/core/per_kind_sliding_window_limiter.sv
rtl/core/pkswl_checker.sv
test/pkswl_monitor.sv
test/tb.sv
